>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/dcpw_pkg.sv
// ---------------------------------------------------------------------------
// dcpw_pkg
// Types and constants of the drive command parser with ping watchdog.
// ---------------------------------------------------------------------------
`default_nettype none

package dcpw_pkg;

    localparam int unsigned EVT_DEPTH = 4;
    localparam int unsigned EVT_PTR_W = $clog2(EVT_DEPTH);
    localparam int unsigned EVT_CNT_W = $clog2(EVT_DEPTH + 1);

    localparam int unsigned MAG_W  = 31;
    localparam int unsigned SECS_W = 9;
    localparam int unsigned TMO_W  = 8;

    localparam logic [TMO_W-1:0]  TMO_RESET = 8'd3;
    localparam logic [SECS_W-1:0] SECS_MAX  = 9'd511;

    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_DIR   = 1'b1;

    typedef enum logic [1:0] {
        PH_OPCODE        = 2'd0,
        PH_SIGN_OR_DIGIT = 2'd1,
        PH_DIGIT         = 2'd2,
        PH_SEMI          = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OPC_NONE = 2'd0,
        OPC_V    = 2'd1,
        OPC_D    = 2'd2,
        OPC_P    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic             stop;
        logic             kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_evt;

endpackage

`default_nettype wire

>>> rtl/core/dcpw_front.sv
// ---------------------------------------------------------------------------
// dcpw_front
// Accepts bytes and ticks, runs the command parser and the ping watchdog,
// and queues one event per speed or direction command or timeout stop.
// ---------------------------------------------------------------------------
`default_nettype none

module dcpw_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dcpw_pkg::TMO_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_accept,
    input  wire logic                        i_op,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_push,
    output dcpw_pkg::t_evt                   o_evt
);

    dcpw_pkg::t_phase                  r_phase, n_phase;
    dcpw_pkg::t_opcode                 r_opc, n_opc;
    logic                              r_neg, n_neg;
    logic [dcpw_pkg::MAG_W-1:0]        r_mag, n_mag;
    logic [dcpw_pkg::SECS_W-1:0]       r_secs, n_secs;
    logic                              r_stop, n_stop;
    logic [dcpw_pkg::TMO_W-1:0]        r_tmo;

    logic                              live;
    logic                              is_digit;
    logic [3:0]                        digit;
    logic [dcpw_pkg::MAG_W+3:0]        mag_x10;
    logic [dcpw_pkg::MAG_W-1:0]        mag_sat;
    logic [dcpw_pkg::SECS_W-1:0]       secs_inc;
    logic                              timeout;

    assign live     = i_accept && !r_stop;
    assign is_digit = (i_rx_byte >= dcpw_pkg::CH_ZERO) && (i_rx_byte <= dcpw_pkg::CH_NINE);
    assign digit    = 4'(i_rx_byte - dcpw_pkg::CH_ZERO);
    assign mag_x10  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                    + {(dcpw_pkg::MAG_W)'(0), digit};
    assign mag_sat  = (mag_x10[dcpw_pkg::MAG_W+3:dcpw_pkg::MAG_W] != 4'd0)
                    ? {dcpw_pkg::MAG_W{1'b1}} : mag_x10[dcpw_pkg::MAG_W-1:0];
    assign secs_inc = (r_secs == dcpw_pkg::SECS_MAX) ? r_secs : r_secs + 1'b1;
    assign timeout  = secs_inc > {1'b0, r_tmo};

    always_comb begin
        n_phase = r_phase;
        n_opc   = r_opc;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_secs  = r_secs;
        n_stop  = r_stop;
        if (live && i_op == dcpw_pkg::OP_TICK) begin
            n_secs = secs_inc;
            n_stop = timeout;
        end else if (live && is_digit) begin
            case (r_phase)
                dcpw_pkg::PH_SIGN_OR_DIGIT: begin
                    n_neg   = 1'b0;
                    n_mag   = {{(dcpw_pkg::MAG_W-4){1'b0}}, digit};
                    n_phase = dcpw_pkg::PH_DIGIT;
                end
                dcpw_pkg::PH_DIGIT: begin
                    n_mag = mag_sat;
                end
                default: begin
                    n_phase = dcpw_pkg::PH_OPCODE;
                end
            endcase
        end else if (live) begin
            case (i_rx_byte)
                dcpw_pkg::CH_V, dcpw_pkg::CH_D, dcpw_pkg::CH_P: begin
                    if (r_phase == dcpw_pkg::PH_OPCODE) begin
                        n_mag = '0;
                        n_neg = 1'b0;
                        if (i_rx_byte == dcpw_pkg::CH_P) begin
                            n_opc   = dcpw_pkg::OPC_P;
                            n_phase = dcpw_pkg::PH_SEMI;
                        end else begin
                            n_opc   = (i_rx_byte == dcpw_pkg::CH_V)
                                    ? dcpw_pkg::OPC_V : dcpw_pkg::OPC_D;
                            n_phase = dcpw_pkg::PH_SIGN_OR_DIGIT;
                        end
                    end else begin
                        n_phase = dcpw_pkg::PH_OPCODE;
                    end
                end
                dcpw_pkg::CH_MINUS: begin
                    if (r_phase == dcpw_pkg::PH_SIGN_OR_DIGIT) begin
                        n_neg   = 1'b1;
                        n_phase = dcpw_pkg::PH_DIGIT;
                    end else begin
                        n_phase = dcpw_pkg::PH_OPCODE;
                    end
                end
                dcpw_pkg::CH_SEMI: begin
                    n_phase = dcpw_pkg::PH_OPCODE;
                    if (r_phase == dcpw_pkg::PH_SEMI && r_opc == dcpw_pkg::OPC_P) begin
                        n_secs = '0;
                    end
                end
                default: begin
                    n_phase = dcpw_pkg::PH_OPCODE;
                end
            endcase
        end
    end

    always_comb begin
        o_push     = 1'b0;
        o_evt.stop = 1'b0;
        o_evt.kind = (r_opc == dcpw_pkg::OPC_D) ? dcpw_pkg::KIND_DIR : dcpw_pkg::KIND_SPEED;
        o_evt.neg  = r_neg;
        o_evt.mag  = r_mag;
        if (live && i_op == dcpw_pkg::OP_TICK) begin
            o_push     = timeout;
            o_evt.stop = 1'b1;
        end else if (live && i_rx_byte == dcpw_pkg::CH_SEMI
                     && r_phase == dcpw_pkg::PH_DIGIT
                     && (r_opc == dcpw_pkg::OPC_V || r_opc == dcpw_pkg::OPC_D)) begin
            o_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dcpw_pkg::PH_OPCODE;
            r_opc   <= dcpw_pkg::OPC_NONE;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_secs  <= '0;
            r_stop  <= 1'b0;
            r_tmo   <= dcpw_pkg::TMO_RESET;
        end else begin
            r_phase <= n_phase;
            r_opc   <= n_opc;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_secs  <= n_secs;
            r_stop  <= n_stop;
            if (i_cfg_we) begin
                r_tmo <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dcpw_evt_fifo.sv
// ---------------------------------------------------------------------------
// dcpw_evt_fifo
// Short event queue between the parser front and the result back end.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dcpw_evt_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dcpw_pkg::t_evt i_evt,
    output logic                o_full,
    output logic                o_valid,
    output dcpw_pkg::t_evt      o_evt,
    input  wire logic           i_pop
);

    localparam logic [dcpw_pkg::EVT_PTR_W-1:0] LAST_PTR =
        (dcpw_pkg::EVT_PTR_W)'(dcpw_pkg::EVT_DEPTH - 1);
    localparam logic [dcpw_pkg::EVT_CNT_W-1:0] FULL_CNT =
        (dcpw_pkg::EVT_CNT_W)'(dcpw_pkg::EVT_DEPTH);

    dcpw_pkg::t_evt                    r_mem [dcpw_pkg::EVT_DEPTH];
    logic [dcpw_pkg::EVT_PTR_W-1:0]    r_wr, r_rd;
    logic [dcpw_pkg::EVT_CNT_W-1:0]    r_count;
    logic                              do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, i_push && o_full && !do_pop)
    `ASSERT_CLK(a_count_in_range, i_clk, i_rst_n, r_count <= FULL_CNT)

endmodule

`default_nettype wire

>>> rtl/core/dcpw_back.sv
// ---------------------------------------------------------------------------
// dcpw_back
// Turns queued events into result items through a registered output stage;
// a timeout stop event expands into a speed and a direction item.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dcpw_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_evt_valid,
    input  wire dcpw_pkg::t_evt i_evt,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_kind,
    output logic signed [31:0]  o_value,
    output logic                o_stopped,
    output logic                o_last
);

    logic               r_valid;
    logic               r_kind;
    logic signed [31:0] r_value;
    logic               r_stopped;
    logic               r_last;
    logic               r_second;

    logic               load;
    logic [31:0]        mag_ext;
    logic [31:0]        cmd_val;

    assign load    = !r_valid || i_ready;
    assign mag_ext = {1'b0, i_evt.mag};
    assign cmd_val = i_evt.neg ? (32'd0 - mag_ext) : mag_ext;
    assign o_pop   = load && i_evt_valid && (!i_evt.stop || r_second);

    always_ff @(posedge i_clk) begin
        if (load && i_evt_valid) begin
            if (i_evt.stop) begin
                r_kind    <= r_second ? dcpw_pkg::KIND_DIR : dcpw_pkg::KIND_SPEED;
                r_value   <= '0;
                r_stopped <= 1'b1;
                r_last    <= r_second;
            end else begin
                r_kind    <= i_evt.kind;
                r_value   <= cmd_val;
                r_stopped <= 1'b0;
                r_last    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= i_evt_valid;
            if (i_evt_valid && i_evt.stop) begin
                r_second <= !r_second;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_value   = r_value;
    assign o_stopped = r_stopped;
    assign o_last    = r_last;

    `ASSERT_CLK(a_stop_pair, i_clk, i_rst_n,
        r_valid && i_ready && r_stopped && !r_last |=>
        r_valid && r_stopped && r_last && r_kind == dcpw_pkg::KIND_DIR)
    `ASSERT_NEVER(a_stop_nonzero, i_clk, i_rst_n, r_valid && r_stopped && r_value != 32'sd0)

endmodule

`default_nettype wire

>>> rtl/core/drive_command_parser_watchdog.sv
// ---------------------------------------------------------------------------
// drive_command_parser_watchdog
// ASCII drive command parser with keep-alive ping watchdog.
// ---------------------------------------------------------------------------
// Takes one item per clock: a received byte (tuser 0) or a one-second tick
// (tuser 1). "v[-]digits;" and "d[-]digits;" give one speed or direction
// result; "P;" clears the ping timer. When a tick pushes the seconds count
// past the timeout register, two stop results follow (speed 0, then
// direction 0, both with the stopped flag) and the block then ignores all
// input until reset. Parsing and the watchdog run in the front end;
// results leave a registered output one per cycle while m_axis_tready is
// high, through a four-entry event queue, and input is held back only
// while that queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module drive_command_parser_watchdog (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dcpw_pkg::TMO_W-1:0]  i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                        s_axis_tuser,  // [0] op
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic signed [31:0]               m_axis_tdata,  // [31:0] cmd_value
    output logic [1:0]                       m_axis_tuser,  // [0] cmd_kind, [1] stopped
    output logic                             m_axis_tlast
);

    logic           accept;
    logic           push;
    logic           full;
    logic           evt_valid;
    logic           pop;
    dcpw_pkg::t_evt evt_in;
    dcpw_pkg::t_evt evt_out;
    logic           out_kind;
    logic           out_stopped;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    dcpw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_op        (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata),
        .o_push      (push),
        .o_evt       (evt_in)
    );

    dcpw_evt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt_in),
        .o_full  (full),
        .o_valid (evt_valid),
        .o_evt   (evt_out),
        .i_pop   (pop)
    );

    dcpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (out_kind),
        .o_value     (m_axis_tdata),
        .o_stopped   (out_stopped),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = {out_stopped, out_kind};

endmodule

`default_nettype wire
